// ----- src/positional_ordered_list_assert.svh -----
// assertion macros shared by the positional ordered list rtl
// depends on nothing; the including module supplies clock and reset names
`ifndef POSITIONAL_ORDERED_LIST_ASSERT_SVH
`define POSITIONAL_ORDERED_LIST_ASSERT_SVH

// same-cycle implication, off while reset is low
`define POL_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off while reset is low
`define POL_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/pol_pkg.sv -----
// types and constants for the positional ordered list
// used by the channel interfaces, the cell and the top level
`timescale 1ns / 1ps

package pol_pkg;

  localparam int VALUE_W  = 32;
  localparam int POS_W    = 16;
  localparam int FUNC_W   = 2;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 6;

  // request operation codes
  typedef enum logic [FUNC_W-1:0] {
    FN_INSERT = 2'd0,
    FN_ERASE  = 2'd1,
    FN_DUMP   = 2'd2,
    FN_NOP    = 2'd3
  } func_t;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_CLAMPED  = 3'd1,
    ST_NEGATIVE = 3'd2,
    ST_FULL     = 3'd3,
    ST_EMPTY    = 3'd4
  } status_t;

  // sequencer states
  typedef enum logic {
    S_IDLE = 1'b0,
    S_DUMP = 1'b1
  } state_t;

  // what every cell does this cycle
  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_ERASE  = 2'd2,
    CELL_ROTATE = 2'd3
  } cell_op_t;

  typedef struct packed {
    cell_op_t               op;
    logic [VALUE_W-1:0]     value;
  } cell_ctrl_t;

endpackage

// ----- src/pol_if.sv -----
// valid/ready channel interfaces for the positional ordered list
// depends on pol_pkg for field widths
`timescale 1ns / 1ps

interface pol_in_if import pol_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [FUNC_W-1:0]         func;
  logic signed [VALUE_W-1:0] value;
  logic signed [POS_W-1:0]   position;

  modport source (output valid, func, value, position, input ready);
  modport sink   (input valid, func, value, position, output ready);
endinterface

interface pol_out_if import pol_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [STATUS_W-1:0]       status;
  logic [COUNT_W-1:0]        count;
  logic signed [VALUE_W-1:0] entry_value;
  logic                      last;

  modport source (output valid, status, count, entry_value, last, input ready);
  modport sink   (input valid, status, count, entry_value, last, output ready);
endinterface

// ----- src/pol_cell.sv -----
// one storage cell of the list chain: holds one entry at a fixed index
// depends on pol_pkg for the cell control struct
`timescale 1ns / 1ps

module pol_cell import pol_pkg::*; #(
  parameter int IDX   = 0,
  parameter int IDX_W = 6
) (
  input  logic               clk,
  input  cell_ctrl_t         ctrl,
  input  logic [IDX_W-1:0]   pos,
  input  logic [IDX_W-1:0]   cnt,
  input  logic [VALUE_W-1:0] left_val,
  input  logic [VALUE_W-1:0] right_val,
  input  logic [VALUE_W-1:0] head_val,
  output logic [VALUE_W-1:0] data
);

  localparam logic [IDX_W-1:0] MY_IDX  = IDX_W'(IDX);
  localparam logic [IDX_W-1:0] MY_NEXT = IDX_W'(IDX + 1);

  logic [VALUE_W-1:0] data_r;
  logic [VALUE_W-1:0] data_nxt;

  // pick own value, the new value or a neighbor
  always_comb begin
    data_nxt = data_r;
    unique case (ctrl.op)
      CELL_HOLD: data_nxt = data_r;
      CELL_INSERT: begin
        priority if (MY_IDX == pos) begin
          data_nxt = ctrl.value;
        end else if (MY_IDX > pos) begin
          data_nxt = left_val;
        end else begin
          data_nxt = data_r;
        end
      end
      CELL_ERASE: begin
        if (MY_IDX >= pos) begin
          data_nxt = right_val;
        end
      end
      CELL_ROTATE: begin
        // rotate the occupied part left by one, head wraps to the tail
        priority if (MY_NEXT < cnt) begin
          data_nxt = right_val;
        end else if (MY_NEXT == cnt) begin
          data_nxt = head_val;
        end else begin
          data_nxt = data_r;
        end
      end
      default: data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;

endmodule

// ----- src/positional_ordered_list.sv -----
// top level of the positional ordered list: sequencer plus chain of cells
// depends on pol_pkg, pol_if, pol_cell and positional_ordered_list_assert.svh
//
//  channel | dir | fields
//  in_ch   | in  | func, value, position
//  out_ch  | out | status, count, entry_value, last
//
// insert, erase, rejected and unused requests are handled on acceptance; the result is
// registered and shows in the cycle after acceptance.
// during a dump of N entries the cell chain rotates once per
// emitted entry and is back in order after the last one.
// reset (rst_n low, synchronous) empties the list; cell contents are not cleared.
// a stalled result holds the chain and blocks new requests until taken.
`timescale 1ns / 1ps
`include "positional_ordered_list_assert.svh"

module positional_ordered_list import pol_pkg::*; #(
  parameter int CAPACITY = 32
) (
  input logic      clk,
  input logic      rst_n,
  pol_in_if.sink   in_ch,
  pol_out_if.source out_ch
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  state_t                state_r, state_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [CNT_W-1:0]      idx_r, idx_nxt;
  logic                  out_valid_r, out_valid_nxt;
  status_t               status_r, status_nxt;
  logic [COUNT_W-1:0]    count_r, count_nxt;
  logic [VALUE_W-1:0]    ev_r, ev_nxt;
  logic                  last_r, last_nxt;

  logic                  out_free;
  logic                  in_rdy;
  logic                  in_acc;
  logic                  out_load;
  logic                  pos_neg;
  logic [POS_W-2:0]      pos_mag;
  logic                  pos_past;
  logic                  pos_at_or_past;
  logic                  dump_last;
  logic [CNT_W-1:0]      cell_pos;
  cell_ctrl_t            cell_ctrl;
  logic [VALUE_W-1:0]    cell_q [CAPACITY];

  // handshake
  assign out_free = !out_valid_r || out_ch.ready;
  assign in_rdy   = (state_r == S_IDLE) && out_free;
  assign in_acc   = in_ch.valid && in_rdy;
  assign in_ch.ready = in_rdy;

  // position decode
  assign pos_neg        = in_ch.position[POS_W-1];
  assign pos_mag        = in_ch.position[POS_W-2:0];
  assign pos_past       = pos_mag > (POS_W-1)'(cnt_r);
  assign pos_at_or_past = pos_mag >= (POS_W-1)'(cnt_r);
  assign dump_last      = CNT_W'(idx_r + 1'b1) == cnt_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc && (in_ch.func == FN_DUMP) && (cnt_r != '0)) begin
          state_nxt = S_DUMP;
        end
      end
      S_DUMP: begin
        if (out_free && dump_last) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath control and result
  always_comb begin
    cell_ctrl.op    = CELL_HOLD;
    cell_ctrl.value = in_ch.value;
    cell_pos        = '0;
    cnt_nxt         = cnt_r;
    idx_nxt         = idx_r;
    out_load        = 1'b0;
    status_nxt      = ST_OK;
    ev_nxt          = '0;
    last_nxt        = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          unique case (func_t'(in_ch.func))
            FN_INSERT: begin
              out_load = 1'b1;
              priority if (pos_neg) begin
                status_nxt = ST_NEGATIVE;
              end else if (cnt_r >= CAP_CNT) begin
                status_nxt = ST_FULL;
              end else begin
                cell_ctrl.op = CELL_INSERT;
                cell_pos     = pos_past ? cnt_r : CNT_W'(pos_mag);
                cnt_nxt      = CNT_W'(cnt_r + 1'b1);
              end
            end
            FN_ERASE: begin
              out_load = 1'b1;
              priority if (pos_neg) begin
                status_nxt = ST_NEGATIVE;
              end else if (cnt_r == '0) begin
                status_nxt = ST_EMPTY;
              end else begin
                cell_ctrl.op = CELL_ERASE;
                cell_pos     = pos_at_or_past ? CNT_W'(cnt_r - 1'b1) : CNT_W'(pos_mag);
                status_nxt   = pos_at_or_past ? ST_CLAMPED : ST_OK;
                cnt_nxt      = CNT_W'(cnt_r - 1'b1);
              end
            end
            FN_DUMP: begin
              if (cnt_r == '0) begin
                out_load   = 1'b1;
                status_nxt = ST_EMPTY;
              end else begin
                idx_nxt = '0;
              end
            end
            FN_NOP: out_load = 1'b1;
            default: out_load = 1'b1;
          endcase
        end
      end
      S_DUMP: begin
        if (out_free) begin
          out_load     = 1'b1;
          ev_nxt       = cell_q[0];
          last_nxt     = dump_last;
          cell_ctrl.op = CELL_ROTATE;
          if (!dump_last) begin
            idx_nxt = CNT_W'(idx_r + 1'b1);
          end
        end
      end
      default: out_load = 1'b0;
    endcase
  end

  assign count_nxt     = COUNT_W'(cnt_nxt);
  assign out_valid_nxt = out_load ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload register
  always_ff @(posedge clk) begin
    if (out_load) begin
      status_r <= status_nxt;
      count_r  <= count_nxt;
      ev_r     <= ev_nxt;
      last_r   <= last_nxt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = status_r;
  assign out_ch.count       = count_r;
  assign out_ch.entry_value = ev_r;
  assign out_ch.last        = last_r;

  // cell chain
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [VALUE_W-1:0] left_v;
    logic [VALUE_W-1:0] right_v;
    if (i == 0) begin : g_first
      assign left_v = '0;
    end else begin : g_mid_l
      assign left_v = cell_q[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_v = '0;
    end else begin : g_mid_r
      assign right_v = cell_q[i+1];
    end
    pol_cell #(
      .IDX   (i),
      .IDX_W (CNT_W)
    ) u_cell (
      .clk       (clk),
      .ctrl      (cell_ctrl),
      .pos       (cell_pos),
      .cnt       (cnt_r),
      .left_val  (left_v),
      .right_val (right_v),
      .head_val  (cell_q[0]),
      .data      (cell_q[i])
    );
  end

  // checks
  `POL_ASSERT_IMP(a_cnt_bound, clk, rst_n, 1'b1, cnt_r <= CAP_CNT, "count above capacity")
  `POL_ASSERT_IMP(a_no_req_in_dump, clk, rst_n, state_r == S_DUMP, !in_ch.ready, "request taken during dump")
  `POL_ASSERT_NXT(a_ins_grows, clk, rst_n, in_acc && (in_ch.func == FN_INSERT) && !pos_neg && (cnt_r < CAP_CNT), cnt_r == CNT_W'($past(cnt_r) + 1'b1), "insert did not grow list")
  `POL_ASSERT_NXT(a_dump_ends, clk, rst_n, (state_r == S_DUMP) && out_free && dump_last, (state_r == S_IDLE) && out_ch.valid && out_ch.last, "dump did not end on last")

endmodule
